[hdl/otm_pkg.sv]
// Shared types and constants for the OS timer match unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package otm_pkg;

    // Number of match registers fitted (1 to 4).
    localparam int NUM_MATCH = 4;

    localparam int DATA_W   = 32;
    localparam int OFFSET_W = 5;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 4;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bus opcodes.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register word indexes.
    localparam logic [IDX_W-1:0] REG_COUNT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_STATUS = 3'd5;
    localparam logic [IDX_W-1:0] REG_WDOG   = 3'd6;
    localparam logic [IDX_W-1:0] REG_IRQEN  = 3'd7;

    localparam logic [DATA_W-1:0] UNALIGNED_VALUE = 32'hdeadbeef;

    // Classified command kinds.
    typedef enum logic [2:0] {
        K_TICK,
        K_READ,
        K_WRITE,
        K_BAD_READ,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

[hdl/os_timer_match_unit.sv]
// Each item passes through the queue, then the output register, before its result is valid.
// Throughput: one item per cycle; a two-entry queue absorbs output stalls before ready drops.
// Every item executes against the register file; four match compares run in parallel.
// Reset (synchronous, active low) clears all timer registers, the queue and the output valid.
// Depends on otm_pkg, otm_front, otm_queue and otm_back.
`default_nettype none

module os_timer_match_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_in_opcode,
    input  wire logic [otm_pkg::OFFSET_W-1:0] i_in_reg_offset,
    input  wire logic [otm_pkg::DATA_W-1:0]   i_in_write_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [otm_pkg::DATA_W-1:0]        o_out_read_data,
    output logic [otm_pkg::STATUS_W-1:0]      o_out_timer_irq
);

    otm_pkg::t_q_status w_q_status;
    otm_pkg::t_cmd      w_push_cmd;
    otm_pkg::t_cmd      w_head_cmd;
    logic               w_push;
    logic               w_pop;

    // Item classification.
    otm_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_opcode     (i_in_opcode),
        .i_in_reg_offset (i_in_reg_offset),
        .i_in_write_data (i_in_write_data),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_cmd           (w_push_cmd)
    );

    // Decoupling queue.
    otm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    // Register file and execution.
    otm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_head_cmd),
        .i_q_status      (w_q_status),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_read_data (o_out_read_data),
        .o_out_timer_irq (o_out_timer_irq)
    );

endmodule

`default_nettype wire

[hdl/otm_front.sv]
// Front end of the OS timer: accepts bus items and classifies them into commands.
// Depends on otm_pkg.
`default_nettype none

module otm_front (
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [1:0]                   i_in_opcode,
    input  wire logic [otm_pkg::OFFSET_W-1:0] i_in_reg_offset,
    input  wire logic [otm_pkg::DATA_W-1:0]   i_in_write_data,
    input  wire otm_pkg::t_q_status           i_q_status,
    output logic                              o_push,
    output otm_pkg::t_cmd                     o_cmd
);

    logic w_aligned;

    // An item is taken whenever the queue has room.
    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;
    assign w_aligned  = (i_in_reg_offset[1:0] == 2'b00);

    // Decode opcode and alignment into a command kind.
    always_comb begin
        o_cmd.idx  = i_in_reg_offset[otm_pkg::OFFSET_W-1:2];
        o_cmd.data = i_in_write_data;
        case (i_in_opcode)
            otm_pkg::OP_TICK:  o_cmd.kind = otm_pkg::K_TICK;
            otm_pkg::OP_READ:  o_cmd.kind = w_aligned ? otm_pkg::K_READ : otm_pkg::K_BAD_READ;
            otm_pkg::OP_WRITE: o_cmd.kind = w_aligned ? otm_pkg::K_WRITE : otm_pkg::K_NOP;
            default:           o_cmd.kind = otm_pkg::K_NOP;
        endcase
    end

endmodule

`default_nettype wire

[hdl/otm_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on otm_pkg.
`default_nettype none

module otm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire otm_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output otm_pkg::t_cmd       o_cmd,
    output otm_pkg::t_q_status  o_status
);

    otm_pkg::t_cmd                  r_mem [otm_pkg::QUEUE_DEPTH];
    logic [otm_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [otm_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [otm_pkg::QCNT_W-1:0]     r_count, n_count;

    localparam logic [otm_pkg::QPTR_W-1:0] LAST_PTR = otm_pkg::QPTR_W'(otm_pkg::QUEUE_DEPTH - 1);
    localparam logic [otm_pkg::QCNT_W-1:0] FULL_CNT = otm_pkg::QCNT_W'(otm_pkg::QUEUE_DEPTH);

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_cmd          = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[hdl/otm_back.sv]
// Back end of the OS timer: holds the register file, executes commands and
// registers each result. Depends on otm_pkg.
`default_nettype none

module otm_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire otm_pkg::t_cmd                 i_cmd,
    input  wire otm_pkg::t_q_status            i_q_status,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [otm_pkg::DATA_W-1:0]         o_out_read_data,
    output logic [otm_pkg::STATUS_W-1:0]       o_out_timer_irq
);

    logic [otm_pkg::DATA_W-1:0]   r_match [otm_pkg::NUM_MATCH];
    logic [otm_pkg::DATA_W-1:0]   n_match [otm_pkg::NUM_MATCH];
    logic [otm_pkg::DATA_W-1:0]   r_count, n_count;
    logic [otm_pkg::STATUS_W-1:0] r_status, n_status;
    logic [otm_pkg::DATA_W-1:0]   r_wdog, n_wdog;
    logic [otm_pkg::DATA_W-1:0]   r_irq_en, n_irq_en;
    logic                         r_out_valid, n_out_valid;
    logic [otm_pkg::DATA_W-1:0]   r_rd_data, n_rd_data;
    logic [otm_pkg::STATUS_W-1:0] w_hit;
    logic [otm_pkg::DATA_W-1:0]   w_rd_value;

    // Take a command when the output slot is free or being emptied.
    assign o_pop = !i_q_status.empty && (!r_out_valid || i_out_ready);

    // Parallel compares of the current count against each fitted match register.
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < otm_pkg::NUM_MATCH; i++) begin
            w_hit[i] = (r_match[i] == r_count);
        end
    end

    // Register read selection.
    always_comb begin
        w_rd_value = '0;
        case (i_cmd.idx)
            otm_pkg::REG_COUNT:  w_rd_value = r_count;
            otm_pkg::REG_STATUS: w_rd_value = {{(otm_pkg::DATA_W-otm_pkg::STATUS_W){1'b0}},
                                               r_status};
            otm_pkg::REG_WDOG:   w_rd_value = r_wdog;
            otm_pkg::REG_IRQEN:  w_rd_value = r_irq_en;
            default: begin
                for (int i = 0; i < otm_pkg::NUM_MATCH; i++) begin
                    if (i_cmd.idx == otm_pkg::IDX_W'(i)) begin
                        w_rd_value = r_match[i];
                    end
                end
            end
        endcase
    end

    // Command execution and next result.
    always_comb begin
        n_match     = r_match;
        n_count     = r_count;
        n_status    = r_status;
        n_wdog      = r_wdog;
        n_irq_en    = r_irq_en;
        n_rd_data   = r_rd_data;
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
            n_rd_data   = '0;
            case (i_cmd.kind)
                otm_pkg::K_TICK: begin
                    n_count  = r_count + 1'b1;
                    n_status = r_status | (w_hit & r_irq_en[otm_pkg::STATUS_W-1:0]);
                end
                otm_pkg::K_READ: begin
                    n_rd_data = w_rd_value;
                end
                otm_pkg::K_BAD_READ: begin
                    n_rd_data = otm_pkg::UNALIGNED_VALUE;
                end
                otm_pkg::K_WRITE: begin
                    case (i_cmd.idx)
                        otm_pkg::REG_COUNT:  n_count = i_cmd.data;
                        otm_pkg::REG_STATUS: n_status = r_status &
                                                 ~i_cmd.data[otm_pkg::STATUS_W-1:0];
                        otm_pkg::REG_WDOG:   n_wdog = i_cmd.data;
                        otm_pkg::REG_IRQEN:  n_irq_en = i_cmd.data;
                        default: begin
                            // Writes to absent match slots are dropped.
                            for (int i = 0; i < otm_pkg::NUM_MATCH; i++) begin
                                if (i_cmd.idx == otm_pkg::IDX_W'(i)) begin
                                    n_match[i] = i_cmd.data;
                                end
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < otm_pkg::NUM_MATCH; i++) begin
                r_match[i] <= '0;
            end
            r_count     <= '0;
            r_status    <= '0;
            r_wdog      <= '0;
            r_irq_en    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_match     <= n_match;
            r_count     <= n_count;
            r_status    <= n_status;
            r_wdog      <= n_wdog;
            r_irq_en    <= n_irq_en;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, loaded with each executed command.
    always_ff @(posedge i_clk) begin
        r_rd_data <= n_rd_data;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_read_data = r_rd_data;
    // The status register is only written together with a result, so it
    // always matches the result being presented.
    assign o_out_timer_irq = r_status;

endmodule

`default_nettype wire

[hdl/otm_checker.sv]
// Port-level checks for the OS timer match unit, bound to the top level.
// Depends on otm_pkg and os_timer_match_unit.
`default_nettype none

module otm_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [otm_pkg::DATA_W-1:0]   o_out_read_data,
    input wire logic [otm_pkg::STATUS_W-1:0] o_out_timer_irq
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_read_data) && $stable(o_out_timer_irq))
        else $error("result changed while stalled");

    // After reset no result is pending and the queue is open.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    // Every transfer in is followed by a valid result, via the queue and the output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("no result two cycles after input transfer");

    // Back-pressure only arises behind a waiting result.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind os_timer_match_unit otm_checker u_otm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_read_data (o_out_read_data),
    .o_out_timer_irq (o_out_timer_irq)
);

`default_nettype wire
